// File: sv/text_terminal_writer_core_assert.svh
// Assertion macros used by the checker file of the text terminal writer.
`ifndef TEXT_TERMINAL_WRITER_CORE_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_CORE_ASSERT_SVH

// A property that is checked only outside reset.
`define TTW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is checked on every edge, reset included.
`define TTW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ttw_pkg.sv
// Shared types and constants of the text terminal writer.
package ttw_pkg;

   // Default screen geometry.
   localparam int TTW_COLUMNS = 80;
   localparam int TTW_ROWS    = 25;

   // Field widths of the beats.
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int READ_INDEX_W = 11;
   localparam int OFFSET_W     = 11;
   localparam int CELL_W       = 16;

   // Item kinds carried in tuser.
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Newline byte and the blank cell: a space in light grey on black.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] cursor_pos;
      logic [CELL_W-1:0]   cell_value;
      logic                scrolled;
   } result_type;

endpackage

// File: sv/ttw_screen_mem.sv
// Screen store: one write port and one registered read port.
module ttw_screen_mem #(
   parameter int DEPTH = 2000
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(DEPTH)-1:0]             wr_addr,
   input  logic [ttw_pkg::CELL_W-1:0]           wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(DEPTH)-1:0]             rd_addr,
   output logic [ttw_pkg::CELL_W-1:0]           rd_data
);
   import ttw_pkg::*;

   logic [CELL_W-1:0] cells_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ttw_ctrl.sv
// Sequencer: cursor, put and read handling, scroll copy and clearing pass.
module ttw_ctrl #(
   parameter int COLUMNS = ttw_pkg::TTW_COLUMNS,
   parameter int ROWS    = ttw_pkg::TTW_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic [ttw_pkg::CHAR_W-1:0]            req_char_code,
   input  logic [ttw_pkg::ATTR_W-1:0]            req_attribute,
   input  logic [ttw_pkg::READ_INDEX_W-1:0]      req_read_index,
   input  logic                                  out_free,
   output logic                                  res_valid,
   output ttw_pkg::result_type                   res_data,
   output logic                                  mem_wr_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_wr_addr,
   output logic [ttw_pkg::CELL_W-1:0]            mem_wr_data,
   output logic                                  mem_rd_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_rd_addr,
   input  logic [ttw_pkg::CELL_W-1:0]            mem_rd_data
);
   import ttw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_LAST  = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int CMP_W      = (CNT_W > READ_INDEX_W) ? CNT_W : READ_INDEX_W;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] res_cell_ff, res_cell_in;
   logic              res_scroll_ff, res_scroll_in;
   logic              read_ok_ff, read_ok_in;

   logic              req_fire;
   logic              is_put;
   logic              is_newline;
   logic              col_last;
   logic              row_last;
   logic              advance_row;
   logic              scroll_needed;
   logic [ADDR_W-1:0] cursor_addr;
   logic [CMP_W-1:0]  index_ext;

   // Decode of the incoming beat and of the cursor.
   assign req_fire      = req_valid && req_ready;
   assign is_put        = (req_opcode == OP_PUT);
   assign is_newline    = (req_char_code == NEWLINE_CODE);
   assign col_last      = (col_ff == COL_W'(COLUMNS - 1));
   assign row_last      = (row_ff == ROW_W'(ROWS - 1));
   assign advance_row   = is_put && (is_newline || col_last);
   assign scroll_needed = advance_row && row_last;
   assign cursor_addr   = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign index_ext     = CMP_W'(req_read_index);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (!is_put) begin
                  state_in = ST_READ;
               end else if (scroll_needed) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_COPY: begin
            if (cnt_ff == CNT_W'(COPY_LAST)) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (cnt_ff == CNT_W'(COLUMNS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs: handshake, result strobe and memory ports.
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cursor_addr;
      mem_wr_data = {req_attribute, req_char_code};
      mem_rd_en   = 1'b0;
      mem_rd_addr = ADDR_W'(index_ext);
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[ADDR_W-1:0];
            mem_wr_data = BLANK_CELL;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_wr_en = req_valid && is_put && !is_newline;
            mem_rd_en = req_valid && !is_put;
         end
         ST_COPY: begin
            // Read one row further down, write back the cell returned by the registered read port.
            mem_rd_en   = (cnt_ff < CNT_W'(COPY_LAST));
            mem_rd_addr = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
            mem_wr_en   = (cnt_ff != '0);
            mem_wr_addr = ADDR_W'(cnt_ff - CNT_W'(1));
            mem_wr_data = mem_rd_data;
         end
         ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_W'(CNT_W'(COPY_LAST) + cnt_ff);
            mem_wr_data = BLANK_CELL;
         end
         ST_DONE: begin
            res_valid = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Sweep counter for the clearing pass, the copy and the bottom-row fill.
   always_comb begin
      cnt_in = '0;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff != CNT_W'(CELL_COUNT - 1)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_COPY: begin
            if (cnt_ff != CNT_W'(COPY_LAST)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FILL: begin
            if (cnt_ff != CNT_W'(COLUMNS - 1)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Cursor update and result capture.
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      res_cell_in   = res_cell_ff;
      res_scroll_in = res_scroll_ff;
      read_ok_in    = read_ok_ff;
      if (state_ff == ST_IDLE && req_fire) begin
         if (is_put) begin
            col_in        = (is_newline || col_last) ? '0 : col_ff + COL_W'(1);
            row_in        = (advance_row && !row_last) ? row_ff + ROW_W'(1) : row_ff;
            res_cell_in   = is_newline ? '0 : {req_attribute, req_char_code};
            res_scroll_in = scroll_needed;
         end else begin
            read_ok_in    = (index_ext < CMP_W'(CELL_COUNT));
            res_scroll_in = 1'b0;
         end
      end else if (state_ff == ST_READ) begin
         res_cell_in = read_ok_ff ? mem_rd_data : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      res_cell_ff   <= res_cell_in;
      res_scroll_ff <= res_scroll_in;
      read_ok_ff    <= read_ok_in;
   end

   assign res_data.cursor_pos = OFFSET_W'(cursor_addr);
   assign res_data.cell_value = res_cell_ff;
   assign res_data.scrolled   = res_scroll_ff;

endmodule

// File: sv/text_terminal_writer_core.sv
// Top level of the text terminal writer: sequencer, screen store and result register.
//
//   channel   direction   beat contents
//   req_      in          tuser: kind; tdata: character, attribute, read index
//   rsp_      out         tdata: cursor offset, cell value, scrolled flag
//
// A put or a newline goes from ST_IDLE to ST_DONE; a read passes ST_READ first for the store's registered read.
// A put that scrolls also passes ST_COPY and ST_FILL: the copy and the blank fill of the
// bottom row each move one cell a cycle through the store's single write port.
// After reset a clearing pass blanks all ROWS*COLUMNS cells of the store; req_tready is
// low throughout. A result waits in the output register while the next beat is taken.
module text_terminal_writer_core #(
   parameter int COLUMNS = ttw_pkg::TTW_COLUMNS,
   parameter int ROWS    = ttw_pkg::TTW_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // char_code[7:0], attribute[15:8], read_index[26:16]
   input  logic [0:0]  req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // cursor_pos[10:0], cell_value[26:11], scrolled[27]
);
   import ttw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int RES_W      = $bits(result_type);

   logic              out_free;
   logic              res_valid;
   result_type        res_data;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   ttw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_opcode     (req_tuser[0]),
      .req_char_code  (req_tdata[7:0]),
      .req_attribute  (req_tdata[15:8]),
      .req_read_index (req_tdata[26:16]),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res_data       (res_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   ttw_screen_mem #(
      .DEPTH (CELL_COUNT)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The output register is free when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Result beat: fields packed from the lowest bit up.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - RES_W){1'b0}}, rsp_data_ff.scrolled,
                        rsp_data_ff.cell_value, rsp_data_ff.cursor_pos};

endmodule

// File: sv/ttw_checker.sv
// Port-level checks on the text terminal writer, bound to its top level.
`include "text_terminal_writer_core_assert.svh"

module ttw_checker #(
   parameter int COLUMNS = ttw_pkg::TTW_COLUMNS,
   parameter int ROWS    = ttw_pkg::TTW_ROWS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import ttw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam logic [OFFSET_W-1:0] BOTTOM_START = OFFSET_W'((ROWS - 1) * COLUMNS);

   logic                rsp_stall;
   logic [OFFSET_W-1:0] rsp_pos;
   logic                scroll_ok;
   logic                pos_ok;

   // Views of the result beat.
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_pos   = rsp_tdata[10:0];
   assign scroll_ok = !rsp_tdata[27] || (rsp_pos == BOTTOM_START);
   assign pos_ok    = (CELL_COUNT > 2048) || (int'(rsp_pos) < CELL_COUNT);

   // A stalled result beat stays offered and unchanged.
   `TTW_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "stalled beat dropped")
   `TTW_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_tdata), "stalled beat changed")

   // The clearing pass keeps the input closed in the cycle after reset.
   `TTW_ASSERT_ALWAYS(a_clear_closed, clock, $past(reset) |-> !req_tready, "open during clear")

   // A scroll always leaves the cursor at the start of the bottom row.
   `TTW_ASSERT(a_scroll_cursor, clock, reset, rsp_tvalid |-> scroll_ok, "scroll off bottom row")

   // The cursor never points past the screen.
   `TTW_ASSERT(a_cursor_range, clock, reset, rsp_tvalid |-> pos_ok, "cursor beyond screen")

endmodule

bind text_terminal_writer_core ttw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_ttw_checker (.*);
